// ===== sv/kpt_pkg.sv =====
// Shared types, constants and helpers for the keyed parameter table.
// Used by every module of the block; depends on nothing.
package kpt_pkg;

  // Field widths of the transactions
  localparam int KEY_W       = 16;
  localparam int TYPE_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int SIZE_IN_W   = 8;
  localparam int SIZE_W      = 4;
  localparam int COUNT_W     = 6;

  // Table geometry
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int MAX_VALUE_BYTES = 8;

  typedef enum logic [1:0] {
    ACT_DEFINE = 2'd0,
    ACT_SET    = 2'd1,
    ACT_GET    = 2'd2,
    ACT_RESET  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SWEEP,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // capture input transaction, rewind scan
    logic step;         // issue next table read
    logic sweep_wr;     // copy default into value for the entry just read
    logic commit_hit;   // finish action on the matched entry
    logic commit_miss;  // finish action with no match
    logic commit_bad;   // finish with bad parameter
    logic commit_ok;    // finish with ok, nothing else
    logic load_out;     // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    size_bad;
    logic    hit;
    logic    done;
    logic    out_free;
  } sts_t;

  // Keep bytes below nbytes, zero the rest
  function automatic logic [VALUE_W-1:0] byte_mask(input logic [SIZE_IN_W-1:0] nbytes);
    logic [VALUE_W-1:0] m;
    m = '0;
    for (int b = 0; b < VALUE_W / 8; b++) begin
      if (nbytes > SIZE_IN_W'(b)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== sv/kpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses kpt_pkg for default sizes only.
module kpt_ram #(
  parameter int WIDTH = kpt_pkg::VALUE_W,
  parameter int DEPTH = kpt_pkg::MAX_ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/kpt_ctrl.sv =====
// Controller state machine of the keyed parameter table.
// Depends on kpt_pkg for state, action and command/status types.
module kpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kpt_pkg::sts_t sts,
  output kpt_pkg::cmd_t cmd
);

  kpt_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      kpt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = kpt_pkg::S_DECODE;
        end
      end
      kpt_pkg::S_DECODE: begin
        unique case (sts.act)
          kpt_pkg::ACT_DEFINE: begin
            if (sts.size_bad) begin
              cmd.commit_bad = 1'b1;
              state_nxt      = kpt_pkg::S_RESP;
            end else begin
              state_nxt = kpt_pkg::S_SCAN;
            end
          end
          kpt_pkg::ACT_SET,
          kpt_pkg::ACT_GET:   state_nxt = kpt_pkg::S_SCAN;
          kpt_pkg::ACT_RESET: state_nxt = kpt_pkg::S_SWEEP;
          default:            state_nxt = kpt_pkg::S_SCAN;
        endcase
      end
      kpt_pkg::S_SCAN: begin
        // keys are unique, so the first match ends the search
        priority if (sts.hit) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = kpt_pkg::S_RESP;
        end else if (sts.done) begin
          cmd.commit_miss = 1'b1;
          state_nxt       = kpt_pkg::S_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      kpt_pkg::S_SWEEP: begin
        cmd.step     = 1'b1;
        cmd.sweep_wr = 1'b1;
        if (sts.done) begin
          cmd.commit_ok = 1'b1;
          state_nxt     = kpt_pkg::S_RESP;
        end
      end
      kpt_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = kpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = kpt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/kpt_datapath.sv =====
// Datapath of the keyed parameter table: transaction registers, table RAMs,
// scan pipeline, entry count and result/output registers.
// Depends on kpt_pkg and kpt_ram.
module kpt_datapath #(
  parameter int MAX_ENTRIES = kpt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kpt_pkg::cmd_t                    cmd,
  output kpt_pkg::sts_t                    sts,
  input  logic [1:0]                       in_action,
  input  logic [kpt_pkg::KEY_W-1:0]        in_param_key,
  input  logic [kpt_pkg::TYPE_W-1:0]       in_param_type,
  input  logic [kpt_pkg::VALUE_W-1:0]      in_value_in,
  input  logic [kpt_pkg::SIZE_IN_W-1:0]    in_size_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [kpt_pkg::VALUE_W-1:0]      out_value_out,
  output logic [kpt_pkg::SIZE_W-1:0]       out_size_out,
  output logic [kpt_pkg::COUNT_W-1:0]      out_entry_count_out
);

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int KW     = kpt_pkg::KEY_W;
  localparam int TW     = kpt_pkg::TYPE_W;
  localparam int VW     = kpt_pkg::VALUE_W;
  localparam int SIW    = kpt_pkg::SIZE_IN_W;
  localparam int SW     = kpt_pkg::SIZE_W;
  localparam int NW     = kpt_pkg::COUNT_W;
  localparam int MW     = TW + SW;

  // Captured transaction
  kpt_pkg::action_t act_r;
  logic [KW-1:0]    key_r;
  logic [TW-1:0]    type_r;
  logic [VW-1:0]    val_r;
  logic [SIW-1:0]   size_r;

  // Scan pipeline and entry count
  logic [CW-1:0] used_r;
  logic [CW-1:0] scan_idx_r;
  logic          chk_vld_r;
  logic [AW-1:0] chk_idx_r;

  // Result and output registers
  kpt_pkg::status_t res_status_r;
  logic [VW-1:0]    res_value_r;
  logic [SW-1:0]    res_size_r;
  logic             out_valid_r;
  kpt_pkg::status_t out_status_r;
  logic [VW-1:0]    out_value_r;
  logic [SW-1:0]    out_size_r;
  logic [NW-1:0]    out_count_r;

  // RAM ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] key_rd;
  logic [MW-1:0] meta_rd;
  logic [VW-1:0] val_rd;
  logic [VW-1:0] dflt_rd;
  logic [SW-1:0] meta_size;
  logic [VW-1:0] mval;
  logic [VW-1:0] val_wdata;
  logic          not_full;
  logic          ins_en;
  logic          def_hit;
  logic          size_match;
  logic          set_ok;
  logic          sweep_we;
  logic          key_we;
  logic          meta_we;
  logic          val_we;

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= kpt_pkg::action_t'(in_action);
      key_r  <= in_param_key;
      type_r <= in_param_type;
      val_r  <= in_value_in;
      size_r <= in_size_in;
    end
  end

  // Table access decode
  always_comb begin
    rd_en      = cmd.step && (scan_idx_r < used_r);
    rd_addr    = scan_idx_r[AW-1:0];
    meta_size  = meta_rd[SW-1:0];
    mval       = val_r & kpt_pkg::byte_mask(size_r);
    not_full   = used_r < CW'(MAX_ENTRIES);
    ins_en     = cmd.commit_miss && (act_r == kpt_pkg::ACT_DEFINE) && not_full;
    def_hit    = cmd.commit_hit && (act_r == kpt_pkg::ACT_DEFINE);
    size_match = size_r == SIW'(meta_size);
    set_ok     = cmd.commit_hit && (act_r == kpt_pkg::ACT_SET) && size_match;
    sweep_we   = cmd.sweep_wr && chk_vld_r;
    key_we     = ins_en;
    meta_we    = ins_en || def_hit;
    val_we     = ins_en || def_hit || set_ok || sweep_we;
    wr_addr    = ins_en ? used_r[AW-1:0] : chk_idx_r;
    val_wdata  = sweep_we ? dflt_rd : mval;
  end

  // Status to controller
  always_comb begin
    sts.act      = act_r;
    sts.size_bad = size_r > SIW'(kpt_pkg::MAX_VALUE_BYTES);
    sts.hit      = chk_vld_r && (key_rd == key_r);
    sts.done     = !chk_vld_r && (scan_idx_r >= used_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Scan pipeline: read address is issued the cycle before its compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      chk_vld_r  <= 1'b0;
    end else if (cmd.accept) begin
      scan_idx_r <= '0;
      chk_vld_r  <= 1'b0;
    end else if (cmd.step) begin
      scan_idx_r <= scan_idx_r + CW'(rd_en);
      chk_vld_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      chk_idx_r <= rd_addr;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ins_en) begin
      used_r <= used_r + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit_bad) begin
      res_status_r <= kpt_pkg::ST_BAD;
      res_value_r  <= '0;
      res_size_r   <= '0;
    end else if (cmd.commit_ok) begin
      res_status_r <= kpt_pkg::ST_OK;
      res_value_r  <= '0;
      res_size_r   <= '0;
    end else if (cmd.commit_hit) begin
      res_status_r <= kpt_pkg::ST_OK;
      res_value_r  <= '0;
      res_size_r   <= '0;
      unique case (act_r)
        kpt_pkg::ACT_SET: begin
          if (!size_match) begin
            res_status_r <= kpt_pkg::ST_BAD;
          end
        end
        kpt_pkg::ACT_GET: begin
          res_value_r <= val_rd;
          res_size_r  <= meta_size;
        end
        default: ;
      endcase
    end else if (cmd.commit_miss) begin
      res_value_r <= '0;
      res_size_r  <= '0;
      if (act_r == kpt_pkg::ACT_DEFINE) begin
        res_status_r <= not_full ? kpt_pkg::ST_OK : kpt_pkg::ST_FULL;
      end else begin
        res_status_r <= kpt_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_size_r   <= res_size_r;
      out_count_r  <= NW'(used_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_value_out       = out_value_r;
  assign out_size_out        = out_size_r;
  assign out_entry_count_out = out_count_r;

  // Table storage
  kpt_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(wr_addr),
    .wdata(key_r),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(key_rd)
  );

  kpt_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(wr_addr),
    .wdata({type_r, size_r[SW-1:0]}),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(meta_rd)
  );

  kpt_ram #(.WIDTH(VW), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(wr_addr),
    .wdata(val_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(val_rd)
  );

  kpt_ram #(.WIDTH(VW), .DEPTH(MAX_ENTRIES)) u_dflt_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(wr_addr),
    .wdata(mval),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(dflt_rd)
  );

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_chk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (CW'(chk_idx_r) < used_r))
    else $error("compare on a slot not in use");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> (used_r == $past(used_r) + CW'(1)))
    else $error("insert did not bump entry count");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded but not presented");

endmodule

// ===== sv/keyed_parameter_table_core.sv =====
// Top level of the keyed parameter table: controller plus datapath.
// Depends on kpt_pkg, kpt_ctrl, kpt_datapath (and kpt_ram below it).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------
//   in_      | input     | in_valid/in_stall  | action, param_key, param_type,
//            |           |                    | value_in, size_in
//   out_     | output    | out_valid/out_stall| status, value_out, size_out,
//            |           |                    | entry_count_out
//
// One transaction at a time. A get, set or define scans the entries in use
// between accept and result: the key scan reads one slot per cycle through
// the table RAM port. Reset-to-defaults sweeps the same way. A define with an
// oversize size finishes without a scan. A stalled result holds in the output
// register; the next transaction is accepted meanwhile and waits for it at the
// end. Reset empties the table.
module keyed_parameter_table_core #(
  parameter int MAX_ENTRIES = kpt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [kpt_pkg::KEY_W-1:0]        in_param_key,
  input  logic [kpt_pkg::TYPE_W-1:0]       in_param_type,
  input  logic [kpt_pkg::VALUE_W-1:0]      in_value_in,
  input  logic [kpt_pkg::SIZE_IN_W-1:0]    in_size_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [kpt_pkg::VALUE_W-1:0]      out_value_out,
  output logic [kpt_pkg::SIZE_W-1:0]       out_size_out,
  output logic [kpt_pkg::COUNT_W-1:0]      out_entry_count_out
);

  kpt_pkg::cmd_t cmd;
  kpt_pkg::sts_t sts;

  // Sequencer
  kpt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Storage and result path
  kpt_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_param_key       (in_param_key),
    .in_param_type      (in_param_type),
    .in_value_in        (in_value_in),
    .in_size_in         (in_size_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_value_out      (out_value_out),
    .out_size_out       (out_size_out),
    .out_entry_count_out(out_entry_count_out)
  );

endmodule
